// ----- rtl/chfge_pkg.sv -----
// Shared constants, opcodes, action codes and handshake structs for the CH-form gate engine.
package chfge_pkg;

    localparam int MAX_QUBITS = 64;
    localparam int QW         = $clog2(MAX_QUBITS);
    localparam int CW         = QW + 1;

    localparam logic [9:0] POWER_MAX = 10'd1023;

    // request opcodes
    localparam logic [3:0] OP_SL    = 4'd0;
    localparam logic [3:0] OP_SR    = 4'd1;
    localparam logic [3:0] OP_CZL   = 4'd2;
    localparam logic [3:0] OP_CZR   = 4'd3;
    localparam logic [3:0] OP_CXL   = 4'd4;
    localparam logic [3:0] OP_CXR   = 4'd5;
    localparam logic [3:0] OP_SWAPR = 4'd6;
    localparam logic [3:0] OP_XL    = 4'd7;
    localparam logic [3:0] OP_HL    = 4'd8;
    localparam logic [3:0] OP_LOAD  = 4'd9;

    // datapath actions issued by the controller
    localparam logic [3:0] ACT_NONE  = 4'd0;
    localparam logic [3:0] ACT_LAT_A = 4'd1;
    localparam logic [3:0] ACT_LAT_B = 4'd2;
    localparam logic [3:0] ACT_SL    = 4'd3;
    localparam logic [3:0] ACT_CZL1  = 4'd4;
    localparam logic [3:0] ACT_CZL2  = 4'd5;
    localparam logic [3:0] ACT_CXL   = 4'd6;
    localparam logic [3:0] ACT_XL    = 4'd7;
    localparam logic [3:0] ACT_HL    = 4'd8;
    localparam logic [3:0] ACT_RPREP = 4'd9;
    localparam logic [3:0] ACT_SWEEP = 4'd10;
    localparam logic [3:0] ACT_LOAD  = 4'd11;

    typedef logic [MAX_QUBITS-1:0] row_t;

    typedef struct packed {
        logic          take;
        logic          rd_en;
        logic [QW-1:0] rd_addr;
        logic [3:0]    act;
        logic          emit;
    } cmd_t;

    typedef struct packed {
        logic [3:0]    op;
        logic          bad;
        logic          need_res;
        logic [QW-1:0] qa;
        logic [QW-1:0] qb;
        logic [CW-1:0] qcount;
    } sts_t;

    // bit of a word selected by a one-hot mask
    function automatic logic bit_sel(input row_t w, input row_t m);
        bit_sel = |(w & m);
    endfunction

    // exchange two columns given as one-hot masks
    function automatic row_t swap_cols(input row_t w, input row_t ma, input row_t mb);
        logic d;
        d = bit_sel(w, ma) ^ bit_sel(w, mb);
        swap_cols = w ^ (d ? (ma | mb) : '0);
    endfunction

endpackage

// ----- rtl/chfge_ctrl.sv -----
// Controller state machine: sequences row reads, gate actions and row sweeps.
module chfge_ctrl
    import chfge_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic out_ready,
    output logic out_valid,
    output logic cfg_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_LATA  = 4'd3;
    localparam logic [3:0] S_LATB  = 4'd4;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_EXEC2 = 4'd6;
    localparam logic [3:0] S_HCHK  = 4'd7;
    localparam logic [3:0] S_RPREP = 4'd8;
    localparam logic [3:0] S_SWEEP = 4'd9;
    localparam logic [3:0] S_TAIL  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovld_reg, ovld_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = ovld_reg;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.act     = ACT_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cnt_next = '0;
                if (sts.bad)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    case (sts.op) inside
                        OP_LOAD:
                        begin
                            cmd.act    = ACT_LOAD;
                            state_next = S_DONE;
                        end
                        OP_SR, OP_CZR, OP_CXR, OP_SWAPR:
                            state_next = S_SWEEP;
                        default:
                            state_next = S_RDA;
                    endcase
                end
            end
            S_RDA:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = sts.qa;
                state_next  = S_LATA;
            end
            S_LATA:
            begin
                cmd.act = ACT_LAT_A;
                if (sts.op == OP_CZL || sts.op == OP_CXL)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = sts.qb;
                    state_next  = S_LATB;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_LATB:
            begin
                cmd.act    = ACT_LAT_B;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (sts.op)
                    OP_SL:  cmd.act = ACT_SL;
                    OP_CZL:
                    begin
                        cmd.act    = ACT_CZL1;
                        state_next = S_EXEC2;
                    end
                    OP_CXL: cmd.act = ACT_CXL;
                    OP_XL:  cmd.act = ACT_XL;
                    OP_HL:
                    begin
                        cmd.act    = ACT_HL;
                        state_next = S_HCHK;
                    end
                    default: cmd.act = ACT_NONE;
                endcase
            end
            S_EXEC2:
            begin
                cmd.act    = ACT_CZL2;
                state_next = S_DONE;
            end
            S_HCHK:
                state_next = sts.need_res ? S_RPREP : S_DONE;
            S_RPREP:
            begin
                cmd.act    = ACT_RPREP;
                cnt_next   = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                // read row cnt while the previous row is written back
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = cnt_reg[QW-1:0];
                if (cnt_reg != '0)
                    cmd.act = ACT_SWEEP;
                if (cnt_reg == sts.qcount - CW'(1))
                    state_next = S_TAIL;
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_TAIL:
            begin
                cmd.act    = ACT_SWEEP;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovld_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // output beat flag
    always_comb
    begin
        if (cmd.emit)
            ovld_next = 1'b1;
        else if (out_ready)
            ovld_next = 1'b0;
        else
            ovld_next = ovld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovld_reg  <= ovld_next;
        end
    end

endmodule

// ----- rtl/chfge_dp.sv -----
// Datapath: F/G/M row memories, phase and basis vectors, amplitude and result register.
module chfge_dp
    import chfge_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          cmd,
    input  logic [3:0]    req_type,
    input  logic [5:0]    qubit_a,
    input  logic [5:0]    qubit_b,
    input  logic          cfg_wr,
    input  logic [6:0]    qubit_count,
    output sts_t          sts,
    output logic          amp_is_zero,
    output logic [2:0]    amp_phase,
    output logic [9:0]    amp_sqrt2_power,
    output logic [63:0]   basis_s,
    output logic [63:0]   basis_v,
    output logic          status
);

    // row memories
    row_t f_mem [MAX_QUBITS];
    row_t g_mem [MAX_QUBITS];
    row_t m_mem [MAX_QUBITS];

    logic          f_we, g_we, m_we;
    logic [QW-1:0] f_wa, g_wa, m_wa;
    row_t          f_wd, g_wd, m_wd;
    row_t          f_rd_reg, g_rd_reg, m_rd_reg;
    logic          fv_rd_reg, gv_rd_reg, mv_rd_reg;
    logic [QW-1:0] row_reg;

    row_t f_vld_reg, f_vld_next, g_vld_reg, g_vld_next, m_vld_reg, m_vld_next;

    logic [CW-1:0] qcnt_reg, qcnt_next;
    logic [3:0]    op_reg, op_next;
    logic [QW-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic          bad_reg, bad_next;

    row_t af_reg, af_next, ag_reg, ag_next, am_reg, am_next;
    row_t bf_reg, bf_next, bg_reg, bg_next, bm_reg, bm_next;
    row_t pl_reg, pl_next, ph_reg, ph_next, s_reg, s_next, v_reg, v_next;
    logic       zero_reg, zero_next;
    logic [2:0] aph_reg, aph_next;
    logic [9:0] apw_reg, apw_next;

    row_t       tgt_reg, tgt_next, piv_reg, piv_next, xm_reg, xm_next, cz_reg, cz_next;
    logic [1:0] dval_reg, dval_next;
    logic       al_reg, al_next, nres_reg, nres_next, mlo_reg, mlo_next, sa_reg, sa_next;

    logic       oz_reg;
    logic [2:0] oph_reg;
    logic [9:0] opw_reg;
    row_t       os_reg, ov_reg;
    logic       ost_reg;

    row_t ef, eg, em, oa, ob;
    logic one_ok, two_ok, in_bad;

    assign oa = row_t'(1) << qa_reg;
    assign ob = row_t'(1) << qb_reg;

    // rows never written read as the basis form
    assign ef = fv_rd_reg ? f_rd_reg : (row_t'(1) << row_reg);
    assign eg = gv_rd_reg ? g_rd_reg : (row_t'(1) << row_reg);
    assign em = mv_rd_reg ? m_rd_reg : '0;

    // index check on the incoming beat
    always_comb
    begin
        one_ok = {1'b0, qubit_a} < qcnt_reg;
        two_ok = one_ok && ({1'b0, qubit_b} < qcnt_reg) && (qubit_a != qubit_b);
        unique case (req_type) inside
            OP_SL, OP_SR, OP_XL, OP_HL:                      in_bad = !one_ok;
            OP_CZL, OP_CZR, OP_CXL, OP_CXR, OP_SWAPR:        in_bad = !two_ok;
            OP_LOAD:                                         in_bad = 1'b0;
            default:                                         in_bad = 1'b1;
        endcase
    end

    assign sts.op       = op_reg;
    assign sts.bad      = bad_reg;
    assign sts.need_res = nres_reg;
    assign sts.qa       = qa_reg;
    assign sts.qb       = qb_reg;
    assign sts.qcount   = qcnt_reg;

    // gate arithmetic
    always_comb
    begin
        row_t       tn, un, diff, lo, hi, src, pm, xm, ynew, nf, ng, nm, f1, g1, m1;
        logic       al, be, gl, gh, odd, sp, yp, vp, sa, sb, sc, mlo, fp, f1p, p;
        logic       xl, xh, plr;
        logic [2:0] pa, pb, gap, ext, turn;
        logic [1:0] wexp, kk;
        logic [6:0] cc;

        qcnt_next = qcnt_reg;
        op_next   = op_reg;
        qa_next   = qa_reg;
        qb_next   = qb_reg;
        bad_next  = bad_reg;
        af_next = af_reg; ag_next = ag_reg; am_next = am_reg;
        bf_next = bf_reg; bg_next = bg_reg; bm_next = bm_reg;
        pl_next = pl_reg; ph_next = ph_reg; s_next = s_reg; v_next = v_reg;
        zero_next = zero_reg; aph_next = aph_reg; apw_next = apw_reg;
        tgt_next = tgt_reg; piv_next = piv_reg; xm_next = xm_reg; cz_next = cz_reg;
        dval_next = dval_reg; al_next = al_reg; nres_next = nres_reg;
        mlo_next = mlo_reg; sa_next = sa_reg;
        f_vld_next = f_vld_reg; g_vld_next = g_vld_reg; m_vld_next = m_vld_reg;
        f_we = 1'b0; g_we = 1'b0; m_we = 1'b0;
        f_wa = qa_reg; g_wa = qa_reg; m_wa = qa_reg;
        f_wd = '0; g_wd = '0; m_wd = '0;
        tn = '0; un = '0; diff = '0; lo = '0; hi = '0; src = '0; pm = '0; xm = '0;
        ynew = '0; nf = '0; ng = '0; nm = '0; f1 = '0; g1 = '0; m1 = '0;
        al = 1'b0; be = 1'b0; gl = 1'b0; gh = 1'b0; odd = 1'b0; sp = 1'b0; yp = 1'b0;
        vp = 1'b0; sa = 1'b0; sb = 1'b0; sc = 1'b0; mlo = 1'b0; fp = 1'b0; f1p = 1'b0;
        p = 1'b0; xl = 1'b0; xh = 1'b0; plr = 1'b0;
        pa = '0; pb = '0; gap = '0; ext = '0; turn = '0; wexp = '0; kk = '0; cc = '0;

        if (cmd.take)
        begin
            op_next  = req_type;
            qa_next  = qubit_a;
            qb_next  = qubit_b;
            bad_next = in_bad;
        end

        case (cmd.act)
            ACT_LAT_A:
            begin
                af_next = ef; ag_next = eg; am_next = em;
            end
            ACT_LAT_B:
            begin
                bf_next = ef; bg_next = eg; bm_next = em;
            end
            ACT_SL:
            begin
                m_we = 1'b1; m_wa = qa_reg; m_wd = am_reg ^ ag_reg;
                pl_next[qa_reg] = ~pl_reg[qa_reg];
                ph_next[qa_reg] = ph_reg[qa_reg] ^ ~pl_reg[qa_reg];
            end
            ACT_CZL1:
            begin
                m_we = 1'b1; m_wa = qa_reg; m_wd = am_reg ^ bg_reg;
            end
            ACT_CZL2:
            begin
                m_we = 1'b1; m_wa = qb_reg; m_wd = bm_reg ^ ag_reg;
            end
            ACT_CXL:
            begin
                ph_next[qa_reg] = ph_reg[qa_reg] ^ (pl_reg[qb_reg] & pl_reg[qa_reg])
                                  ^ ph_reg[qb_reg] ^ (^(am_reg & bf_reg));
                pl_next[qa_reg] = pl_reg[qa_reg] ^ pl_reg[qb_reg];
                g_we = 1'b1; g_wa = qb_reg; g_wd = bg_reg ^ ag_reg;
                f_we = 1'b1; f_wa = qa_reg; f_wd = af_reg ^ bf_reg;
                m_we = 1'b1; m_wa = qa_reg; m_wd = am_reg ^ bm_reg;
            end
            ACT_XL:
            begin
                tn  = s_reg ^ (am_reg & v_reg);
                odd = (^(am_reg & ~v_reg & s_reg)) ^ (^(af_reg & v_reg & tn));
                s_next = tn ^ (af_reg & ~v_reg);
                turn = {odd ^ ph_reg[qa_reg], pl_reg[qa_reg], 1'b0};
                if (!zero_reg)
                    aph_next = aph_reg + turn;
            end
            ACT_HL:
            begin
                tn = s_reg ^ (ag_reg & v_reg);
                un = s_reg ^ ((af_reg & ~v_reg) ^ (am_reg & v_reg));
                al = ^(ag_reg & ~v_reg & s_reg);
                be = ^((am_reg & ~v_reg & s_reg) ^ (af_reg & v_reg & (am_reg ^ s_reg)));
                gl = pl_reg[qa_reg];
                gh = ph_reg[qa_reg];
                s_next = tn;
                nres_next = 1'b0;
                if (tn == un)
                begin
                    pa  = {al, 2'b00};
                    pb  = {be ^ gh, gl, 1'b0};
                    gap = pb - pa;
                    case (gap)
                        3'd4:
                        begin
                            zero_next = 1'b1; aph_next = '0; apw_next = '0;
                        end
                        3'd0:
                        begin
                            if (!zero_reg)
                            begin
                                aph_next = aph_reg + pa;
                                if (apw_reg < POWER_MAX)
                                    apw_next = apw_reg + 10'd1;
                            end
                        end
                        3'd2:
                            if (!zero_reg) aph_next = aph_reg + pa + 3'd1;
                        default:
                            if (!zero_reg) aph_next = aph_reg + pa + 3'd7;
                    endcase
                end
                else
                begin
                    tgt_next  = un;
                    dval_next = {gh ^ al ^ be, gl};
                    al_next   = al;
                    nres_next = 1'b1;
                end
            end
            ACT_RPREP:
            begin
                // pick the pivot and settle s, v and w for the merged term
                diff = s_reg ^ tgt_reg;
                lo   = ~v_reg & diff;
                hi   = v_reg & diff;
                mlo  = |lo;
                src  = mlo ? lo : hi;
                pm   = src & (~src + row_t'(1));
                xm   = src & ~pm;
                sp   = bit_sel(s_reg, pm);
                ynew = sp ? (tgt_reg ^ pm) : s_reg;
                yp   = bit_sel(ynew, pm);
                wexp = yp ? dval_reg : 2'd0;
                kk   = yp ? (2'd0 - dval_reg) : dval_reg;
                vp   = bit_sel(v_reg, pm);
                if (!vp)
                begin
                    sb = 1'b1; sa = kk[0]; sc = kk[1];
                end
                else
                begin
                    case (kk)
                        2'd1:
                        begin
                            sa = 1'b1; sb = 1'b1; sc = 1'b1; ext = 3'd1;
                        end
                        2'd2: sc = 1'b1;
                        2'd3:
                        begin
                            sa = 1'b1; sb = 1'b1; ext = 3'd7;
                        end
                        default: sc = 1'b0;
                    endcase
                end
                s_next = (ynew & ~pm) | (sc ? pm : '0);
                v_next = (v_reg & ~pm) | (sb ? pm : '0);
                turn = {wexp, 1'b0} + ext + {al_reg, 2'b00};
                if (!zero_reg)
                    aph_next = aph_reg + turn;
                piv_next = pm;
                xm_next  = xm;
                cz_next  = mlo ? hi : '0;
                mlo_next = mlo;
                sa_next  = sa;
            end
            ACT_SWEEP:
            begin
                // one row of a right-hand gate or of the Hadamard merge
                nf  = ef; ng = eg; nm = em;
                plr = pl_reg[row_reg];
                case (op_reg)
                    OP_SR:
                    begin
                        fp = bit_sel(ef, oa);
                        nm = em ^ (fp ? oa : '0);
                        xl = fp;
                        xh = fp & ~plr;
                    end
                    OP_CZR:
                    begin
                        fp  = bit_sel(ef, oa);
                        f1p = bit_sel(ef, ob);
                        nm  = em ^ (f1p ? oa : '0) ^ (fp ? ob : '0);
                        xh  = fp & f1p;
                    end
                    OP_CXR:
                    begin
                        ng = eg ^ (bit_sel(eg, ob) ? oa : '0);
                        nf = ef ^ (bit_sel(ef, oa) ? ob : '0);
                        nm = em ^ (bit_sel(em, ob) ? oa : '0);
                    end
                    OP_SWAPR:
                    begin
                        ng = swap_cols(eg, oa, ob);
                        nf = swap_cols(ef, oa, ob);
                        nm = swap_cols(em, oa, ob);
                    end
                    default:
                    begin
                        // merged CX chain, CZ set and optional S on the pivot
                        if (mlo_reg)
                        begin
                            fp = bit_sel(ef, piv_reg);
                            f1 = ef ^ (fp ? xm_reg : '0);
                            g1 = eg ^ ((^(eg & xm_reg)) ? piv_reg : '0);
                            m1 = em ^ ((^(em & xm_reg)) ? piv_reg : '0);
                        end
                        else
                        begin
                            g1 = eg ^ (bit_sel(eg, piv_reg) ? xm_reg : '0);
                            f1 = ef ^ ((^(ef & xm_reg)) ? piv_reg : '0);
                            m1 = em ^ (bit_sel(em, piv_reg) ? xm_reg : '0);
                        end
                        p   = ^(f1 & cz_reg);
                        f1p = bit_sel(f1, piv_reg);
                        m1  = m1 ^ (p ? piv_reg : '0) ^ (f1p ? cz_reg : '0);
                        xh  = f1p & p;
                        if (sa_reg)
                        begin
                            m1 = m1 ^ (f1p ? piv_reg : '0);
                            xl = f1p;
                            xh = xh ^ (f1p & ~plr);
                        end
                        nf = f1; ng = g1; nm = m1;
                    end
                endcase
                pl_next[row_reg] = plr ^ xl;
                ph_next[row_reg] = ph_reg[row_reg] ^ xh;
                f_we = 1'b1; f_wa = row_reg; f_wd = nf;
                g_we = 1'b1; g_wa = row_reg; g_wd = ng;
                m_we = 1'b1; m_wa = row_reg; m_wd = nm;
            end
            default:
            begin
                nf = '0;
            end
        endcase

        if (f_we) f_vld_next[f_wa] = 1'b1;
        if (g_we) g_vld_next[g_wa] = 1'b1;
        if (m_we) m_vld_next[m_wa] = 1'b1;

        // basis reload, also on every count write
        if (cmd.act == ACT_LOAD || cfg_wr)
        begin
            f_vld_next = '0; g_vld_next = '0; m_vld_next = '0;
            pl_next = '0; ph_next = '0; s_next = '0; v_next = '0;
            zero_next = 1'b0; aph_next = '0; apw_next = '0;
        end

        if (cfg_wr)
        begin
            cc = qubit_count;
            if (cc == 7'd0)
                qcnt_next = CW'(1);
            else if (cc > 7'(MAX_QUBITS))
                qcnt_next = CW'(MAX_QUBITS);
            else
                qcnt_next = cc;
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (f_we) f_mem[f_wa] <= f_wd;
        if (g_we) g_mem[g_wa] <= g_wd;
        if (m_we) m_mem[m_wa] <= m_wd;
        if (cmd.rd_en)
        begin
            f_rd_reg  <= f_mem[cmd.rd_addr];
            g_rd_reg  <= g_mem[cmd.rd_addr];
            m_rd_reg  <= m_mem[cmd.rd_addr];
            fv_rd_reg <= f_vld_reg[cmd.rd_addr];
            gv_rd_reg <= g_vld_reg[cmd.rd_addr];
            mv_rd_reg <= m_vld_reg[cmd.rd_addr];
            row_reg   <= cmd.rd_addr;
        end
    end

    // working registers and result register
    always_ff @(posedge clk)
    begin
        op_reg <= op_next; qa_reg <= qa_next; qb_reg <= qb_next; bad_reg <= bad_next;
        af_reg <= af_next; ag_reg <= ag_next; am_reg <= am_next;
        bf_reg <= bf_next; bg_reg <= bg_next; bm_reg <= bm_next;
        tgt_reg <= tgt_next; piv_reg <= piv_next; xm_reg <= xm_next; cz_reg <= cz_next;
        dval_reg <= dval_next; al_reg <= al_next; mlo_reg <= mlo_next; sa_reg <= sa_next;
        if (cmd.emit)
        begin
            oz_reg  <= zero_reg;
            oph_reg <= zero_reg ? 3'd0 : aph_reg;
            opw_reg <= zero_reg ? 10'd0 : apw_reg;
            os_reg  <= s_reg;
            ov_reg  <= v_reg;
            ost_reg <= bad_reg;
        end
    end

    // state that reset brings to the basis form
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcnt_reg  <= CW'(MAX_QUBITS);
            f_vld_reg <= '0;
            g_vld_reg <= '0;
            m_vld_reg <= '0;
            pl_reg    <= '0;
            ph_reg    <= '0;
            s_reg     <= '0;
            v_reg     <= '0;
            zero_reg  <= 1'b0;
            aph_reg   <= '0;
            apw_reg   <= '0;
            nres_reg  <= 1'b0;
        end
        else
        begin
            qcnt_reg  <= qcnt_next;
            f_vld_reg <= f_vld_next;
            g_vld_reg <= g_vld_next;
            m_vld_reg <= m_vld_next;
            pl_reg    <= pl_next;
            ph_reg    <= ph_next;
            s_reg     <= s_next;
            v_reg     <= v_next;
            zero_reg  <= zero_next;
            aph_reg   <= aph_next;
            apw_reg   <= apw_next;
            nres_reg  <= nres_next;
        end
    end

    assign amp_is_zero     = oz_reg;
    assign amp_phase       = oph_reg;
    assign amp_sqrt2_power = opw_reg;
    assign basis_s         = os_reg;
    assign basis_v         = ov_reg;
    assign status          = ost_reg;

endmodule

// ----- rtl/ch_form_clifford_gate_engine_core.sv -----
// Top level of the CH-form stabilizer gate engine: controller plus datapath.
//
// Usage: each input beat (req_type, qubit_a, qubit_b) applies one gate to the
// held CH-form state and yields exactly one output beat with the amplitude,
// the s and v vectors and a status bit (1 = rejected, state unchanged).
// Items are handled one at a time; in_ready is high only while the engine
// is idle, and it stays high while a finished result waits on out_ready.
// Right-hand gates and a left Hadamard that merges two terms sweep the
// first qubit_count rows of the F/G/M memories, one row per cycle through
// a single read port.
// Reset (rst_n low, asynchronous) sets qubit_count to 64 and loads the
// computational-basis form; a cfg write of qubit_count (accepted only when
// idle) clamps it to 1..64 and reloads the basis form as well.
// If the receiver stalls, the result is held on the output and the engine
// waits before it can deliver the next one.
module ch_form_clifford_gate_engine_core
    import chfge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  req_type,
    input  logic [5:0]  qubit_a,
    input  logic [5:0]  qubit_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        amp_is_zero,
    output logic [2:0]  amp_phase,
    output logic [9:0]  amp_sqrt2_power,
    output logic [63:0] basis_s,
    output logic [63:0] basis_v,
    output logic        status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  qubit_count
);

    cmd_t cmd;
    sts_t sts;
    logic cfg_wr;

    assign cfg_wr = cfg_valid & cfg_ready;

    chfge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    chfge_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .req_type        (req_type),
        .qubit_a         (qubit_a),
        .qubit_b         (qubit_b),
        .cfg_wr          (cfg_wr),
        .qubit_count     (qubit_count),
        .sts             (sts),
        .amp_is_zero     (amp_is_zero),
        .amp_phase       (amp_phase),
        .amp_sqrt2_power (amp_sqrt2_power),
        .basis_s         (basis_s),
        .basis_v         (basis_v),
        .status          (status)
    );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the CH-form stabilizer gate engine.
module tb;
    import chfge_pkg::*;

    // Result fields of one beat
    typedef struct {
        bit        zero;
        bit [2:0]  phase;
        bit [9:0]  power;
        bit [63:0] s;
        bit [63:0] v;
        bit        bad;
    } amp_result_t;

    // Tracks the CH-form state, predicts each result and checks the outputs
    class ch_state_tracker;
        bit [63:0] f_rows[64];
        bit [63:0] g_rows[64];
        bit [63:0] m_rows[64];
        bit [63:0] ph_lo, ph_hi, s_vec, v_vec;
        bit        w_zero;
        bit [2:0]  w_phase;
        bit [9:0]  w_power;
        int unsigned nq;
        amp_result_t pending_results[$];
        int errors;

        function new();
            errors = 0;
            nq = MAX_QUBITS;
            load_basis();
        endfunction

        function bit [63:0] act_mask();
            if (nq >= 64) return '1;
            return (64'd1 << nq) - 64'd1;
        endfunction

        function void turn(int unsigned e);
            if (!w_zero) w_phase = w_phase + 3'(e);
        endfunction

        function void load_basis();
            for (int r = 0; r < 64; r++) begin
                f_rows[r] = (r < nq) ? (64'd1 << r) : 64'd0;
                g_rows[r] = f_rows[r];
                m_rows[r] = 64'd0;
            end
            ph_lo = 0; ph_hi = 0; s_vec = 0; v_vec = 0;
            w_zero = 0; w_phase = 0; w_power = 0;
        endfunction

        function void set_count(bit [6:0] val);
            int unsigned c;
            c = val;
            if (c < 1) c = 1;
            if (c > MAX_QUBITS) c = MAX_QUBITS;
            nq = c;
            load_basis();
        endfunction

        function void s_right(int t);
            bit fb;
            for (int r = 0; r < nq; r++) begin
                fb = f_rows[r][t];
                m_rows[r][t] = m_rows[r][t] ^ fb;
                ph_lo[r] = ph_lo[r] ^ fb;
                ph_hi[r] = ph_hi[r] ^ (fb & ph_lo[r]);
            end
        endfunction

        function void cz_right(int a, int b);
            bit fa, fb;
            for (int r = 0; r < nq; r++) begin
                fa = f_rows[r][a];
                fb = f_rows[r][b];
                m_rows[r][a] = m_rows[r][a] ^ fb;
                m_rows[r][b] = m_rows[r][b] ^ fa;
                ph_hi[r] = ph_hi[r] ^ (fa & fb);
            end
        endfunction

        function void cx_right(int c, int t);
            for (int r = 0; r < nq; r++) begin
                g_rows[r][c] = g_rows[r][c] ^ g_rows[r][t];
                f_rows[r][t] = f_rows[r][t] ^ f_rows[r][c];
                m_rows[r][c] = m_rows[r][c] ^ m_rows[r][t];
            end
        endfunction

        function void cx_left(int c, int t);
            ph_hi[c] = ph_hi[c] ^ (ph_lo[t] & ph_lo[c]);
            ph_lo[c] = ph_lo[c] ^ ph_lo[t];
            ph_hi[c] = ph_hi[c] ^ ph_hi[t];
            ph_hi[c] = ph_hi[c] ^ (^(m_rows[c] & f_rows[t] & act_mask()));
            g_rows[t] = g_rows[t] ^ g_rows[c];
            f_rows[c] = f_rows[c] ^ f_rows[t];
            m_rows[c] = m_rows[c] ^ m_rows[t];
        endfunction

        function bit [63:0] swap_bits(bit [63:0] w, int a, int b);
            bit d;
            d = w[a] ^ w[b];
            w[a] = w[a] ^ d;
            w[b] = w[b] ^ d;
            return w;
        endfunction

        function void x_left(int t);
            bit odd;
            odd = 0;
            for (int c = 0; c < nq; c++) begin
                if (m_rows[t][c]) begin
                    if (v_vec[c]) s_vec[c] = ~s_vec[c];
                    else if (s_vec[c]) odd = ~odd;
                end
                if (f_rows[t][c]) begin
                    if (v_vec[c]) begin
                        if (s_vec[c]) odd = ~odd;
                    end
                    else s_vec[c] = ~s_vec[c];
                end
            end
            turn(((odd ^ ph_hi[t]) ? 4 : 0) + (ph_lo[t] ? 2 : 0));
        endfunction

        // merge s + i^d * target into a single term
        function void resolve(bit [63:0] target, int unsigned d);
            bit [63:0] diff, lo, hi, ynew;
            int piv;
            bit found, sa, sb, sc;
            int unsigned wexp, kk, extra;
            diff = (s_vec ^ target) & act_mask();
            lo = ~v_vec & diff;
            hi = v_vec & diff;
            piv = 0; found = 0; wexp = 0; kk = d & 3;
            sa = 0; sb = 0; sc = 0; extra = 0;
            if (diff == 0) return;
            if (lo != 0) begin
                for (int c = 0; c < nq; c++) begin
                    if (lo[c]) begin
                        if (!found) begin piv = c; found = 1; end
                        else cx_right(piv, c);
                    end
                end
                for (int c = 0; c < nq; c++)
                    if (hi[c]) cz_right(piv, c);
            end
            else begin
                for (int c = 0; c < nq; c++) begin
                    if (hi[c]) begin
                        if (!found) begin piv = c; found = 1; end
                        else cx_right(c, piv);
                    end
                end
            end
            if (s_vec[piv]) begin
                ynew = target;
                ynew[piv] = ~ynew[piv];
            end
            else ynew = s_vec;
            if (ynew[piv]) begin
                wexp = d & 3;
                kk = (4 - wexp) & 3;
            end
            if (!v_vec[piv]) begin
                sb = 1; sa = kk[0]; sc = kk[1];
            end
            else if (kk == 1) begin
                sa = 1; sb = 1; sc = 1; extra = 1;
            end
            else if (kk == 2) sc = 1;
            else if (kk == 3) begin
                sa = 1; sb = 1; extra = 7;
            end
            s_vec = ynew;
            s_vec[piv] = sc;
            v_vec[piv] = sb;
            turn(2 * wexp + extra);
            if (sa) s_right(piv);
        endfunction

        function void h_left(int t);
            bit [63:0] mk, vv, ss, tnew, unew;
            bit al, be, gl, gh;
            int unsigned pa, pb, gap;
            mk = act_mask(); vv = v_vec; ss = s_vec;
            tnew = ss ^ (g_rows[t] & vv);
            unew = ss ^ ((f_rows[t] & ~vv) ^ (m_rows[t] & vv));
            al = ^(g_rows[t] & ~vv & ss & mk);
            be = ^(((m_rows[t] & ~vv & ss) ^ (f_rows[t] & vv & (m_rows[t] ^ ss))) & mk);
            gl = ph_lo[t]; gh = ph_hi[t];
            s_vec = tnew;
            if (tnew == unew) begin
                pa = al ? 4 : 0;
                pb = ((be ^ gh) ? 4 : 0) + (gl ? 2 : 0);
                gap = (pb - pa) & 7;
                if (gap == 4) begin
                    w_zero = 1; w_phase = 0; w_power = 0;
                end
                else if (gap == 0) begin
                    turn(pa);
                    if (!w_zero && w_power < POWER_MAX) w_power++;
                end
                else if (gap == 2) turn(pa + 1);
                else turn(pa + 7);
            end
            else begin
                resolve(unew, (gl + 2 * gh + 2 * (al + be)) & 3);
                if (al) turn(4);
            end
        endfunction

        // apply one accepted request and queue its predicted result
        function void note_request(bit [3:0] op, bit [5:0] a, bit [5:0] b);
            amp_result_t r;
            bit one_ok, two_ok, bad;
            one_ok = a < nq;
            two_ok = one_ok && b < nq && a != b;
            bad = 0;
            case (op)
                OP_SL:    if (one_ok) begin
                              m_rows[a] = m_rows[a] ^ g_rows[a];
                              ph_lo[a] = ~ph_lo[a];
                              ph_hi[a] = ph_hi[a] ^ ph_lo[a];
                          end else bad = 1;
                OP_SR:    if (one_ok) s_right(a); else bad = 1;
                OP_CZL:   if (two_ok) begin
                              m_rows[a] = m_rows[a] ^ g_rows[b];
                              m_rows[b] = m_rows[b] ^ g_rows[a];
                          end else bad = 1;
                OP_CZR:   if (two_ok) cz_right(a, b); else bad = 1;
                OP_CXL:   if (two_ok) cx_left(a, b); else bad = 1;
                OP_CXR:   if (two_ok) cx_right(a, b); else bad = 1;
                OP_SWAPR: if (two_ok) begin
                              for (int r2 = 0; r2 < nq; r2++) begin
                                  g_rows[r2] = swap_bits(g_rows[r2], a, b);
                                  f_rows[r2] = swap_bits(f_rows[r2], a, b);
                                  m_rows[r2] = swap_bits(m_rows[r2], a, b);
                              end
                          end else bad = 1;
                OP_XL:    if (one_ok) x_left(a); else bad = 1;
                OP_HL:    if (one_ok) h_left(a); else bad = 1;
                OP_LOAD:  load_basis();
                default:  bad = 1;
            endcase
            r.zero = w_zero;
            r.phase = w_zero ? 3'd0 : w_phase;
            r.power = w_zero ? 10'd0 : w_power;
            r.s = s_vec;
            r.v = v_vec;
            r.bad = bad;
            pending_results.push_back(r);
        endfunction

        function void check_result(amp_result_t got);
            amp_result_t exp_r;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat");
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.zero != exp_r.zero || got.phase != exp_r.phase ||
                got.power != exp_r.power || got.s != exp_r.s ||
                got.v != exp_r.v || got.bad != exp_r.bad) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp z%0d p%0d w%0d s%h v%h st%0d, got z%0d p%0d w%0d s%h v%h st%0d",
                             exp_r.zero, exp_r.phase, exp_r.power, exp_r.s, exp_r.v, exp_r.bad,
                             got.zero, got.phase, got.power, got.s, got.v, got.bad);
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_ready, out_valid, out_ready;
    logic [3:0]  req_type;
    logic [5:0]  qubit_a, qubit_b;
    logic        amp_is_zero, status;
    logic [2:0]  amp_phase;
    logic [9:0]  amp_sqrt2_power;
    logic [63:0] basis_s, basis_v;
    logic        cfg_valid, cfg_ready;
    logic [6:0]  qubit_count;

    ch_state_tracker tracker;
    int idle_cycles;
    int stall_mode, stall_left;

    ch_form_clifford_gate_engine_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .qubit_a(qubit_a), .qubit_b(qubit_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .amp_is_zero(amp_is_zero), .amp_phase(amp_phase),
        .amp_sqrt2_power(amp_sqrt2_power), .basis_s(basis_s),
        .basis_v(basis_v), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .qubit_count(qubit_count)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // result monitor and no-progress watchdog
    always @(posedge clk) begin
        amp_result_t got;
        if (out_valid && out_ready) begin
            got.zero = amp_is_zero; got.phase = amp_phase; got.power = amp_sqrt2_power;
            got.s = basis_s; got.v = basis_v; got.bad = status;
            tracker.check_result(got);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stalls: modes of full speed, random and mostly stalled
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 80);
        end
        else stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // one request beat; valid stays up until accepted
    task send_req(input bit [3:0] op, input bit [5:0] a, input bit [5:0] b);
        @(negedge clk);
        in_valid = 1'b1;
        req_type = op; qubit_a = a; qubit_b = b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_request(op, a, b);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task drain();
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task write_count(input bit [6:0] val);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        qubit_count = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.set_count(val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random gates, mostly valid indices, in bursts with gaps
    task random_gates(input int count);
        int burst, n;
        bit [3:0] op;
        bit [5:0] a, b;
        burst = 0;
        n = tracker.nq;
        for (int k = 0; k < count; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge clk);
            end
            burst--;
            if ($urandom_range(0, 19) == 0) op = 4'($urandom_range(10, 15));
            else if ($urandom_range(0, 3) == 0) op = OP_HL;
            else if ($urandom_range(0, 30) == 0) op = OP_LOAD;
            else op = 4'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) begin
                a = 6'($urandom); b = 6'($urandom);
            end
            else begin
                a = 6'($urandom_range(0, n - 1));
                b = 6'($urandom_range(0, n - 1));
                if (n > 1) while (b == a) b = 6'($urandom_range(0, n - 1));
            end
            if (k == count / 2) drain();
            send_req(op, a, b);
        end
    endtask

    initial begin
        tracker = new();
        idle_cycles = 0;
        stall_mode = 0; stall_left = 0;
        rst_n = 0;
        in_valid = 0; req_type = 0; qubit_a = 0; qubit_b = 0;
        out_ready = 0; cfg_valid = 0; qubit_count = 7'd64;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, each opcode, bad indices, superposition merges
        send_req(OP_HL, 0, 0);
        send_req(OP_HL, 63, 0);
        send_req(OP_CXR, 0, 63);
        send_req(OP_CZR, 63, 0);
        send_req(OP_SWAPR, 0, 63);
        send_req(OP_SR, 63, 0);
        send_req(OP_SL, 0, 0);
        send_req(OP_CZL, 0, 63);
        send_req(OP_CXL, 63, 0);
        send_req(OP_XL, 0, 0);
        send_req(OP_XL, 63, 63);
        send_req(OP_HL, 0, 0);
        send_req(OP_SL, 0, 0);
        send_req(OP_HL, 0, 0);
        send_req(OP_HL, 63, 0);
        send_req(OP_CXR, 5, 5);
        send_req(OP_SWAPR, 63, 63);
        send_req(4'd10, 0, 0);
        send_req(4'd15, 63, 63);
        send_req(OP_LOAD, 63, 63);
        send_req(OP_SL, 0, 0);
        send_req(OP_HL, 0, 0);
        send_req(OP_HL, 0, 0);
        random_gates(180);

        write_count(7'd0);
        send_req(OP_SL, 1, 0);
        send_req(OP_CZR, 0, 1);
        send_req(OP_HL, 0, 0);
        random_gates(50);
        write_count(7'd2);
        random_gates(100);
        write_count(7'd127);
        random_gates(150);
        write_count(7'd5);
        random_gates(100);
        write_count(7'd64);
        random_gates(100);

        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- ch_form_clifford_gate_engine_core.f -----
rtl/chfge_pkg.sv
rtl/chfge_ctrl.sv
rtl/chfge_dp.sv
rtl/ch_form_clifford_gate_engine_core.sv
tb/sv/tb.sv
